// ----- hdl/fla_pkg.sv -----
package fla_pkg;

	// request codes
	localparam logic [1:0] REQ_BOOT   = 2'd0;
	localparam logic [1:0] REQ_LOOP   = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	// fault bit positions
	localparam int unsigned FAULT_W   = 7;
	localparam int unsigned FLT_WDT   = 0;
	localparam int unsigned FLT_SLOW  = 1;
	localparam int unsigned FLT_TURN  = 2;
	localparam int unsigned FLT_HORN  = 3;
	localparam int unsigned FLT_BRAKE = 4;
	localparam int unsigned FLT_LINK  = 5;
	localparam int unsigned FLT_NEVER = 6;

	// latched event bits, kept across updates until acknowledged
	localparam logic [FAULT_W-1:0] LATCHED_MASK = 7'b000_0011;
	// the link bit never lights the lamp
	localparam logic [FAULT_W-1:0] LAMP_ALLOWED = 7'b101_1111;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAMP_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEVER_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_NORM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_FAULT = 3'd4;

	// reset values
	localparam logic [FAULT_W-1:0] LAMP_MASK_RST   = 7'd95 & LAMP_ALLOWED;
	localparam logic [31:0]        SLOW_LIMIT_RST  = 32'd20000;
	localparam logic [31:0]        NEVER_LIMIT_RST = 32'd2000000;
	localparam logic [15:0]        BLINK_NORM_RST  = 16'd500;
	localparam logic [15:0]        BLINK_FAULT_RST = 16'd125;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        wdt_reset;
		logic [31:0] loop_us;
		logic [31:0] now_ms;
		logic        turn_conflict;
		logic        horn_stuck;
		logic        brake_stuck;
		logic        link_up;
		logic        ever_braked;
		logic [31:0] odometer_mm;
		logic        ack_rise;
		logic        display_blanking;
	} in_item_t;

	typedef struct packed {
		logic [FAULT_W-1:0] fault_vector;
		logic               lamp_on;
		logic               heartbeat_on;
		logic [31:0]        loop_last_us;
		logic [31:0]        loop_max_us;
	} out_item_t;

	typedef struct packed {
		logic [FAULT_W-1:0] lamp_mask;
		logic [31:0]        loop_slow_limit_us;
		logic [31:0]        brake_never_limit_mm;
		logic [15:0]        blink_normal_ms;
		logic [15:0]        blink_fault_ms;
	} cfg_t;

endpackage

// ----- hdl/fault_latch_ack_annunciator_unit.sv -----
// seven-bit fault annunciator: boot items clear the faults and latch the
// watchdog bit, loop items track last and max loop time and latch slow loop,
// update items rebuild the live faults, take acknowledgements and run the
// heartbeat. one item is accepted per clock while the result side keeps up;
// an item lands in the input register at its transfer edge and its result is
// then registered into the result register once that register is free, and
// offered from there. all the per-item work, one 32-bit subtract and
// several 32-bit compares, sits between the two registers. configuration
// writes are always taken (cfg_ready is tied high) and should only be issued
// while the unit is idle.
module fault_latch_ack_annunciator_unit
	import fla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t cfg;

	// pipeline registers
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;

	// block state
	logic [FAULT_W-1:0] fault_q;
	logic [FAULT_W-1:0] acked_q;
	logic [31:0]        loop_last_q;
	logic [31:0]        loop_max_q;
	logic [31:0]        beat_time_q;
	logic               beat_level_q;

	// next state for the item in stage 1
	logic [FAULT_W-1:0] fault_nx;
	logic [FAULT_W-1:0] acked_nx;
	logic [31:0]        loop_last_nx;
	logic [31:0]        loop_max_nx;
	logic [31:0]        beat_time_nx;
	logic               beat_level_nx;
	logic [FAULT_W-1:0] live_faults;
	logic [15:0]        half_period;
	logic [31:0]        beat_elapsed;
	out_item_t          result_nx;

	logic advance;
	logic step_fire;

	assign cfg_ready = 1'b1;

	fla_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// result register is free, or is being emptied this cycle
	assign advance   = !valid_s2 || !out_stall;
	assign step_fire = valid_s1 && advance;
	// hold the input only when stage 1 is full and cannot move on
	assign in_stall  = valid_s1 && !advance;

	// live condition bits of an update item
	always_comb begin
		live_faults            = '0;
		live_faults[FLT_TURN]  = item_s1.turn_conflict;
		live_faults[FLT_HORN]  = item_s1.horn_stuck;
		live_faults[FLT_BRAKE] = item_s1.brake_stuck;
		live_faults[FLT_LINK]  = !item_s1.link_up;
		live_faults[FLT_NEVER] = !item_s1.ever_braked
			&& (item_s1.odometer_mm > cfg.brake_never_limit_mm);
	end

	always_comb begin
		fault_nx      = fault_q;
		acked_nx      = acked_q;
		loop_last_nx  = loop_last_q;
		loop_max_nx   = loop_max_q;
		beat_time_nx  = beat_time_q;
		beat_level_nx = beat_level_q;
		half_period   = '0;
		beat_elapsed  = '0;
		case (item_s1.req_type)
			REQ_BOOT: begin
				fault_nx          = '0;
				fault_nx[FLT_WDT] = item_s1.wdt_reset;
				acked_nx          = '0;
			end
			REQ_LOOP: begin
				loop_last_nx = item_s1.loop_us;
				if (item_s1.loop_us > loop_max_q) begin
					loop_max_nx = item_s1.loop_us;
				end
				if (item_s1.loop_us > cfg.loop_slow_limit_us) begin
					fault_nx[FLT_SLOW] = 1'b1;
				end
			end
			REQ_UPDATE: begin
				// keep latched events, rebuild the live bits
				fault_nx = (fault_q & LATCHED_MASK) | live_faults;
				if (item_s1.ack_rise) begin
					fault_nx = fault_nx & ~LATCHED_MASK;
					acked_nx = acked_q | (fault_nx & cfg.lamp_mask);
				end
				// an acknowledgement drops once its fault clears
				acked_nx = acked_nx & fault_nx;
				// heartbeat, on the fault half period while any fault is set
				half_period  = (|fault_nx) ? cfg.blink_fault_ms : cfg.blink_normal_ms;
				beat_elapsed = item_s1.now_ms - beat_time_q;
				if (beat_elapsed >= {16'd0, half_period}) begin
					beat_time_nx  = item_s1.now_ms;
					beat_level_nx = !beat_level_q;
				end
			end
			default: begin
				// unused request type, state unchanged
			end
		endcase
	end

	always_comb begin
		result_nx.fault_vector = fault_nx;
		result_nx.lamp_on      = |(fault_nx & cfg.lamp_mask & ~acked_nx);
		result_nx.heartbeat_on = beat_level_nx && !item_s1.display_blanking;
		result_nx.loop_last_us = loop_last_nx;
		result_nx.loop_max_us  = loop_max_nx;
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			result_s2 <= result_nx;
		end
	end

	// state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q      <= '0;
			acked_q      <= '0;
			loop_last_q  <= '0;
			loop_max_q   <= '0;
			beat_time_q  <= '0;
			beat_level_q <= 1'b0;
		end else if (step_fire) begin
			fault_q      <= fault_nx;
			acked_q      <= acked_nx;
			loop_last_q  <= loop_last_nx;
			loop_max_q   <= loop_max_nx;
			beat_time_q  <= beat_time_nx;
			beat_level_q <= beat_level_nx;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// acknowledgements only cover faults that are set
	a_acked_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(acked_q & ~fault_q) == '0)
		else $error("acked bit without matching fault");

	// largest loop time never below the last one
	a_loop_max: assert property (@(posedge clk) disable iff (!arst_n)
		loop_max_q >= loop_last_q)
		else $error("loop max below loop last");

	// link fault never reaches the lamp
	a_link_unmasked: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.lamp_mask[FLT_LINK])
		else $error("link bit set in lamp mask");

	// a lit lamp needs a fault in the same result
	a_lamp_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lamp_on |-> out_data.fault_vector != '0)
		else $error("lamp lit with no fault");

	// a result held by the sink keeps the next item parked in stage 1
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stage 1 emptied while stalled");

endmodule

// ----- hdl/fla_cfg_regs.sv -----
module fla_cfg_regs
	import fla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lamp_mask            <= LAMP_MASK_RST;
			cfg_q.loop_slow_limit_us   <= SLOW_LIMIT_RST;
			cfg_q.brake_never_limit_mm <= NEVER_LIMIT_RST;
			cfg_q.blink_normal_ms      <= BLINK_NORM_RST;
			cfg_q.blink_fault_ms       <= BLINK_FAULT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_LAMP_MASK: begin
					cfg_q.lamp_mask <= wr_data[FAULT_W-1:0] & LAMP_ALLOWED;
				end
				CFG_SLOW_LIMIT: begin
					cfg_q.loop_slow_limit_us <= wr_data;
				end
				CFG_NEVER_LIMIT: begin
					cfg_q.brake_never_limit_mm <= wr_data;
				end
				CFG_BLINK_NORM: begin
					cfg_q.blink_normal_ms <= wr_data[15:0];
				end
				CFG_BLINK_FAULT: begin
					cfg_q.blink_fault_ms <= wr_data[15:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- tb/tb_fault_latch_ack_annunciator_unit.sv -----
module tb_fault_latch_ack_annunciator_unit;
	import fla_pkg::*;

	// cycles with no transfer on any channel before the run is called hung
	localparam int unsigned IDLE_LIMIT = 2000;
	// quiet cycles after the last result before a register write or the end
	localparam int unsigned SETTLE_CYCLES = 6;
	// request code the unit does not define, reports state unchanged
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// register index past the end of the map, write is dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	fault_latch_ack_annunciator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the register file as the unit should hold it
	logic [FAULT_W-1:0] sh_lamp_mask;
	logic [31:0]        sh_slow_limit;
	logic [31:0]        sh_never_limit;
	logic [15:0]        sh_blink_norm;
	logic [15:0]        sh_blink_fault;

	// predicted annunciator state
	logic [FAULT_W-1:0] fl_faults;
	logic [FAULT_W-1:0] fl_acked;
	logic [31:0]        fl_loop_last;
	logic [31:0]        fl_loop_max;
	logic [31:0]        fl_beat_time;
	logic               fl_beat_level;

	// fault reports still owed by the unit, oldest first
	out_item_t   annunciations_due[$];
	out_item_t   due_head;
	int unsigned error_count;
	int unsigned idle_cycles;
	// both sides skip their random waits while set
	bit          no_idle;
	// receiver wait before the next result, drawn per transfer
	int unsigned rx_wait;
	// long receiver hold-off, counted down by the receiver itself
	int unsigned long_hold;
	// millisecond time stamp fed to update items, advanced by each drawn update
	logic [31:0] sim_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predicted result of one accepted item, advancing the shadow state
	function automatic out_item_t annunciate(in_item_t it);
		out_item_t          r;
		logic [FAULT_W-1:0] live;
		logic [31:0]        half;
		logic [31:0]        elapsed;
		case (it.req_type)
			REQ_BOOT: begin
				fl_faults = '0;
				fl_acked = '0;
				if (it.wdt_reset)
					fl_faults[FLT_WDT] = 1'b1;
			end
			REQ_LOOP: begin
				fl_loop_last = it.loop_us;
				if (it.loop_us > fl_loop_max)
					fl_loop_max = it.loop_us;
				// strict compare against the limit
				if (it.loop_us > sh_slow_limit)
					fl_faults[FLT_SLOW] = 1'b1;
			end
			REQ_UPDATE: begin
				// latched events survive, live conditions are rebuilt
				live = fl_faults & LATCHED_MASK;
				live[FLT_TURN] = it.turn_conflict;
				live[FLT_HORN] = it.horn_stuck;
				live[FLT_BRAKE] = it.brake_stuck;
				live[FLT_LINK] = ~it.link_up;
				live[FLT_NEVER] = ~it.ever_braked && (it.odometer_mm > sh_never_limit);
				fl_faults = live;
				if (it.ack_rise) begin
					fl_faults = fl_faults & ~LATCHED_MASK;
					fl_acked = fl_acked | (fl_faults & sh_lamp_mask);
				end
				// an acknowledgement drops once its fault clears
				fl_acked = fl_acked & fl_faults;
				half = (fl_faults != '0) ? {16'd0, sh_blink_fault} : {16'd0, sh_blink_norm};
				// wrapping elapsed time, a zero half period toggles every update
				elapsed = it.now_ms - fl_beat_time;
				if (elapsed >= half) begin
					fl_beat_time = it.now_ms;
					fl_beat_level = ~fl_beat_level;
				end
			end
			default: ;
		endcase
		r.fault_vector = fl_faults;
		r.lamp_on = |(fl_faults & sh_lamp_mask & ~fl_acked);
		r.heartbeat_on = fl_beat_level & ~it.display_blanking;
		r.loop_last_us = fl_loop_last;
		r.loop_max_us = fl_loop_max;
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	// every field random, so fields an item ignores still toggle
	function automatic in_item_t noise_item();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t boot_item(logic wdt);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_BOOT;
		it.wdt_reset = wdt;
		return it;
	endfunction

	function automatic in_item_t loop_item(logic [31:0] us);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_LOOP;
		it.loop_us = us;
		return it;
	endfunction

	// conds packs turn, horn, brake, link up, ever braked
	function automatic in_item_t update_item(logic [31:0] now, logic [4:0] conds,
			logic [31:0] odo, logic ack, logic blank);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_UPDATE;
		it.now_ms = now;
		{it.turn_conflict, it.horn_stuck, it.brake_stuck, it.link_up, it.ever_braked} = conds;
		it.odometer_mm = odo;
		it.ack_rise = ack;
		it.display_blanking = blank;
		return it;
	endfunction

	// mostly updates with realistic time steps, values bunched at the thresholds
	function automatic in_item_t draw_item();
		in_item_t    it;
		int unsigned pick;
		logic [31:0] us;
		logic [31:0] odo;
		logic [4:0]  conds;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			it = boot_item(1'($urandom_range(0, 1)));
		end else if (pick < 22) begin
			case ($urandom_range(0, 3))
				0: us = sh_slow_limit + $urandom_range(0, 4) - 2;
				1: us = $urandom;
				default: us = $urandom_range(0, 40000);
			endcase
			it = loop_item(us);
		end else if (pick < 97) begin
			case ($urandom_range(0, 9))
				7, 8: sim_ms = sim_ms + $urandom_range(0, 70000);
				9: sim_ms = sim_ms + $urandom;
				default: sim_ms = sim_ms + $urandom_range(0, 200);
			endcase
			case ($urandom_range(0, 3))
				0: odo = sh_never_limit + $urandom_range(0, 2) - 1;
				1: odo = $urandom;
				default: odo = $urandom_range(0, 3000000);
			endcase
			conds = {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
				$urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0,
				$urandom_range(0, 1) == 1};
			it = update_item(sim_ms, conds, odo, $urandom_range(0, 5) == 0,
				$urandom_range(0, 7) == 0);
		end else begin
			it = noise_item();
			it.req_type = REQ_UNUSED;
		end
		return it;
	endfunction

	// one input transfer; valid stays high on return so the next item can follow
	task automatic offer_item(in_item_t it);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop offering and wait for every owed report, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (annunciations_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic release_registers();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(cfg_t s);
		write_register(CFG_LAMP_MASK, {25'd0, s.lamp_mask});
		write_register(CFG_SLOW_LIMIT, s.loop_slow_limit_us);
		write_register(CFG_NEVER_LIMIT, s.brake_never_limit_mm);
		write_register(CFG_BLINK_NORM, {16'd0, s.blink_normal_ms});
		write_register(CFG_BLINK_FAULT, {16'd0, s.blink_fault_ms});
		release_registers();
	endtask

	// boot, loop and update corners under the reset register values
	task automatic test_reset_values();
		in_item_t it;
		// nothing wrong, time zero, no toggle yet
		offer_item(update_item(32'd0, 5'b00011, 32'd0, 1'b0, 1'b0));
		// unused request code leaves everything as it is
		it = noise_item();
		it.req_type = REQ_UNUSED;
		offer_item(it);
		offer_item(boot_item(1'b1));
		// loop time equal to the limit does not latch, one above does
		offer_item(loop_item(SLOW_LIMIT_RST));
		offer_item(loop_item(SLOW_LIMIT_RST + 32'd1));
		offer_item(loop_item(32'd0));
		offer_item(loop_item(32'hFFFF_FFFF));
		// every live fault at once, past the odometer limit with no braking
		offer_item(update_item(32'd100, 5'b11100, NEVER_LIMIT_RST + 32'd1, 1'b0, 1'b0));
		// acknowledge: latched bits clear, lamp goes dark, heartbeat toggles
		offer_item(update_item(32'd225, 5'b11100, NEVER_LIMIT_RST + 32'd1, 1'b1, 1'b0));
		// turn conflict clears, its ack goes away, display blanked
		offer_item(update_item(32'd226, 5'b01100, NEVER_LIMIT_RST + 32'd1, 1'b0, 1'b1));
		// odometer exactly at the limit does not fault
		offer_item(update_item(32'd400, 5'b00010, NEVER_LIMIT_RST, 1'b0, 1'b0));
		offer_item(boot_item(1'b0));
		// link down alone, far ahead in time
		offer_item(update_item(32'hFFFF_FF00, 5'b00001, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// time wrapped past zero, ack with nothing latched
		offer_item(update_item(32'd50, 5'b00011, 32'hFFFF_FFFF, 1'b1, 1'b0));
		drain_results();
	endtask

	// limits at zero and at full scale, zero half periods, ignored index
	task automatic test_threshold_extremes();
		cfg_t s;
		// all data bits set: link bit forced off, upper bits dropped
		write_register(CFG_LAMP_MASK, 32'hFFFF_FFFF);
		write_register(CFG_SLOW_LIMIT, 32'd0);
		write_register(CFG_NEVER_LIMIT, 32'd0);
		write_register(CFG_BLINK_NORM, 32'd0);
		write_register(CFG_BLINK_FAULT, 32'hFFFF_0000);
		write_register(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
		release_registers();
		offer_item(loop_item(32'd0));
		offer_item(loop_item(32'd1));
		offer_item(update_item(32'd10, 5'b00010, 32'd1, 1'b0, 1'b0));
		// same time stamp, zero half period still toggles
		offer_item(update_item(32'd10, 5'b00011, 32'd1, 1'b0, 1'b0));
		offer_item(update_item(32'd11, 5'b10010, 32'd1, 1'b1, 1'b0));
		drain_results();
		s.lamp_mask = '0;
		s.loop_slow_limit_us = 32'hFFFF_FFFF;
		s.brake_never_limit_mm = 32'hFFFF_FFFF;
		s.blink_normal_ms = 16'hFFFF;
		s.blink_fault_ms = 16'hFFFF;
		apply_settings(s);
		offer_item(loop_item(32'hFFFF_FFFF));
		offer_item(update_item(32'd20, 5'b11100, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// empty lamp mask keeps the lamp dark whatever is set
		offer_item(boot_item(1'b1));
		drain_results();
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_input_backpressure();
		@(posedge clk);
		long_hold = 80;
		no_idle = 1'b1;
		repeat (30) offer_item(draw_item());
		no_idle = 1'b0;
		drain_results();
	endtask

	// random traffic under reset, low extreme, high extreme and random settings
	task automatic test_random_settings();
		cfg_t s;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					s.lamp_mask = LAMP_MASK_RST;
					s.loop_slow_limit_us = SLOW_LIMIT_RST;
					s.brake_never_limit_mm = NEVER_LIMIT_RST;
					s.blink_normal_ms = BLINK_NORM_RST;
					s.blink_fault_ms = BLINK_FAULT_RST;
				end
				1: begin
					s.lamp_mask = 7'h7F;
					s.loop_slow_limit_us = 32'd0;
					s.brake_never_limit_mm = 32'd0;
					s.blink_normal_ms = 16'd1;
					s.blink_fault_ms = 16'd1;
				end
				2: begin
					s.lamp_mask = '0;
					s.loop_slow_limit_us = 32'hFFFF_FFFF;
					s.brake_never_limit_mm = 32'hFFFF_FFFF;
					s.blink_normal_ms = 16'hFFFF;
					s.blink_fault_ms = 16'hFFFF;
				end
				default: begin
					s.lamp_mask = 7'($urandom);
					s.loop_slow_limit_us = $urandom_range(0, 40000);
					s.brake_never_limit_mm = $urandom_range(0, 4000000);
					s.blink_normal_ms = 16'($urandom_range(1, 600));
					s.blink_fault_ms = 16'($urandom_range(1, 200));
				end
			endcase
			apply_settings(s);
			// time close to the wrap point for one phase
			if (p == 3)
				sim_ms = 32'hFFFF_F000;
			for (int n = 0; n < 240; n++) begin
				no_idle = (n < 40) && (p % 2 == 1);
				// sender pause until every report is back
				if (n == 120)
					drain_results();
				offer_item(draw_item());
			end
			no_idle = 1'b0;
			drain_results();
		end
	endtask

	// receiver: random wait per result, long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold != 0) begin
				out_stall <= 1'b1;
				long_hold--;
			end else if (rx_wait != 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// scoreboard: check the output transfer first, then predict the input one
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (annunciations_due.size() == 0) begin
					report_error($sformatf("report with none owed, fault_vector %h",
						out_data.fault_vector));
				end else begin
					due_head = annunciations_due.pop_front();
					if (out_data.fault_vector !== due_head.fault_vector)
						report_error($sformatf("fault_vector got %h want %h",
							out_data.fault_vector, due_head.fault_vector));
					if (out_data.lamp_on !== due_head.lamp_on)
						report_error($sformatf("lamp_on got %b want %b",
							out_data.lamp_on, due_head.lamp_on));
					if (out_data.heartbeat_on !== due_head.heartbeat_on)
						report_error($sformatf("heartbeat_on got %b want %b",
							out_data.heartbeat_on, due_head.heartbeat_on));
					if (out_data.loop_last_us !== due_head.loop_last_us)
						report_error($sformatf("loop_last_us got %h want %h",
							out_data.loop_last_us, due_head.loop_last_us));
					if (out_data.loop_max_us !== due_head.loop_max_us)
						report_error($sformatf("loop_max_us got %h want %h",
							out_data.loop_max_us, due_head.loop_max_us));
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (in_valid && !in_stall)
				annunciations_due.push_back(annunciate(in_data));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LAMP_MASK:   sh_lamp_mask = cfg_data[FAULT_W-1:0] & LAMP_ALLOWED;
					CFG_SLOW_LIMIT:  sh_slow_limit = cfg_data;
					CFG_NEVER_LIMIT: sh_never_limit = cfg_data;
					CFG_BLINK_NORM:  sh_blink_norm = cfg_data[15:0];
					CFG_BLINK_FAULT: sh_blink_fault = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// hang guard: any transfer on any channel resets the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** fault_latch_ack_annunciator_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		rx_wait = 0;
		long_hold = 0;
		sim_ms = '0;
		sh_lamp_mask = LAMP_MASK_RST;
		sh_slow_limit = SLOW_LIMIT_RST;
		sh_never_limit = NEVER_LIMIT_RST;
		sh_blink_norm = BLINK_NORM_RST;
		sh_blink_fault = BLINK_FAULT_RST;
		fl_faults = '0;
		fl_acked = '0;
		fl_loop_last = '0;
		fl_loop_max = '0;
		fl_beat_time = '0;
		fl_beat_level = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_values();
		test_threshold_extremes();
		test_input_backpressure();
		test_random_settings();
		drain_results();
		if (error_count == 0)
			$display("** fault_latch_ack_annunciator_unit: PASSED **");
		else
			$display("** fault_latch_ack_annunciator_unit: FAILED **");
		$finish;
	end

endmodule
